>>> rtl/a2dct_pkg.sv
// Shared types, constants and the quarter-wave sine table for the 2-D composite transform.
// Depends on nothing; the RTL files refer to it by scoped names, the bench files import it.
package a2dct_pkg;

  localparam int ANGLE_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int QS         = ANGLE_BITS - 2;
  localparam int QN         = 1 << QS;
  localparam int ACC_W      = 66 - FRAC_BITS;
  localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;

  typedef logic signed [31:0] q_t;
  localparam q_t ONE_Q = q_t'(1) <<< FRAC_BITS;

  typedef enum logic [2:0] {
    REQ_IDENT = 3'd0,
    REQ_TRANS = 3'd1,
    REQ_SCALE = 3'd2,
    REQ_ROT   = 3'd3,
    REQ_VERT  = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    DST_M2 = 3'd0,
    DST_M5 = 3'd1,
    DST_NW = 3'd2,
    DST_RX = 3'd3,
    DST_RY = 3'd4
  } dst_e;

  typedef struct packed {
    logic [2:0] req_type;
    q_t         x_a;
    q_t         y_a;
    q_t         pivot_x;
    q_t         pivot_y;
    logic [9:0] angle;
  } in_word_t;

  typedef struct packed {
    q_t out_x;
    q_t out_y;
  } out_word_t;

  // One multiply-accumulate step as it travels down the shared unit.
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       neg;
    logic       last;
    dst_e       dst;
    logic [2:0] idx;
    q_t         base;
  } step_t;

  // Saturated result of a finished sum and where it goes.
  typedef struct packed {
    logic       valid;
    dst_e       dst;
    logic [2:0] idx;
    q_t         data;
  } wr_t;

  typedef logic [QN:0][FRAC_BITS:0] sin_tab_t;

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Unsigned restoring division, used only while the sine table is built.
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series of the sine in unsigned Q2.62, rounded to FRAC_BITS.
  function automatic logic [FRAC_BITS:0] quarter_sine(int i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] dv;
    logic [63:0] ii;
    ii   = 64'(i);
    x    = (PI_HALF_Q62 >> QS) * ii
         + (((PI_HALF_Q62 & ((64'd1 << QS) - 64'd1)) * ii) >> QS);
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n <= 15; n++) begin
      dv   = 64'((2 * n) * (2 * n + 1));
      term = div_u64(mul_q62(term, x2), dv);
      if ((n & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    sum = (sum + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
    return sum[FRAC_BITS:0];
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    for (int i = 0; i <= QN; i++) begin
      t[i] = quarter_sine(i);
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  function automatic q_t sine_of(logic [ANGLE_BITS-1:0] a);
    logic [1:0]    q;
    logic [QS-1:0] r;
    logic [QS:0]   idx;
    q_t            v;
    q   = a[ANGLE_BITS-1:ANGLE_BITS-2];
    r   = a[QS-1:0];
    idx = q[0] ? ((QS+1)'(QN) - {1'b0, r}) : {1'b0, r};
    v   = q_t'({1'b0, SIN_TAB[idx]});
    return q[1] ? -v : v;
  endfunction

endpackage

>>> rtl/a2dct_sine.sv
// Sine and cosine lookup for the rotation request.
// Uses the quarter-wave table and the quadrant folding from a2dct_pkg.
module a2dct_sine (
  input  logic [a2dct_pkg::ANGLE_BITS-1:0] angle_i,
  output a2dct_pkg::q_t                    sin_o,
  output a2dct_pkg::q_t                    cos_o
);

  logic [a2dct_pkg::ANGLE_BITS-1:0] cos_ang;

  // Cosine is the sine a quarter turn later; the add wraps around the full turn.
  assign cos_ang = angle_i + a2dct_pkg::ANGLE_BITS'(a2dct_pkg::QN);
  assign sin_o   = a2dct_pkg::sine_of(angle_i);
  assign cos_o   = a2dct_pkg::sine_of(cos_ang);

endmodule

>>> rtl/a2dct_mul.sv
// Shared signed 32 x 32 multiplier stage with its step control carried alongside.
// Depends on a2dct_pkg for the operand and step types.
module a2dct_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  a2dct_pkg::q_t         a_i,
  input  a2dct_pkg::q_t         b_i,
  input  a2dct_pkg::step_t      step_i,
  output logic signed [63:0]    prod_o,
  output a2dct_pkg::step_t      step_o
);

  logic signed [63:0] prod_q;
  a2dct_pkg::step_t   step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign prod_o = prod_q;
  assign step_o = step_q;

endmodule

>>> rtl/a2dct_acc.sv
// Accumulator behind the shared multiplier: shift, add or subtract, saturate.
// Depends on a2dct_pkg for the widths and the step and write types.
module a2dct_acc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [63:0] prod_i,
  input  a2dct_pkg::step_t   step_i,
  output a2dct_pkg::wr_t     wr_o
);

  localparam int AW = a2dct_pkg::ACC_W;

  logic signed [AW-1:0] acc_q;
  logic signed [AW-1:0] part;
  logic signed [AW-1:0] term;
  logic signed [AW-1:0] start;
  logic signed [AW-1:0] sum;
  logic                 fits;

  // The product floors by the fraction width through an arithmetic part-select.
  assign part  = {{2{prod_i[63]}}, prod_i[63:a2dct_pkg::FRAC_BITS]};
  assign term  = step_i.neg ? -part : part;
  assign start = step_i.first ? {{(AW-32){step_i.base[31]}}, step_i.base} : acc_q;
  assign sum   = start + term;
  assign fits  = (&sum[AW-1:31]) | ~(|sum[AW-1:31]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (step_i.valid) begin
      acc_q <= sum;
    end
  end

  always_comb begin
    wr_o.valid = step_i.valid & step_i.last;
    wr_o.dst   = step_i.dst;
    wr_o.idx   = step_i.idx;
    if (fits) begin
      wr_o.data = sum[31:0];
    end else if (sum[AW-1]) begin
      wr_o.data = 32'sh8000_0000;
    end else begin
      wr_o.data = 32'sh7FFF_FFFF;
    end
  end

endmodule

>>> rtl/affine_2d_composite_transform.sv
// Top level of the 2-D composite transform: sequencer, matrix registers, output register.
// Depends on a2dct_pkg, a2dct_sine, a2dct_mul and a2dct_acc.
//
// Usage: one input channel (in_valid_i, in_ready_o, in_data_i) carries request words and
// one output channel (out_valid_o, out_ready_i, out_data_o) carries transformed vertices.
// A word is taken when valid and ready are both high at a rising clock edge.
// Identity requests and unused request codes finish in the accepting cycle and leave the
// block ready at once. Translate, scale and rotate requests run 12, 14 and 16 steps through
// one shared multiplier, followed by a drain state and a commit state, then return to idle.
// A vertex request runs 4 steps, then a drain state and the output state, which loads its
// result word into the output register once that register is free.
// The block is busy (in_ready_o low) while a request runs. A finished vertex waits in the
// output register; matrix requests keep running while that word waits, and a second vertex
// holds in its final state until the receiver has taken the first word.
// Reset is asynchronous and active low; it loads the identity matrix and empties the output.
module affine_2d_composite_transform (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  a2dct_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output a2dct_pkg::out_word_t out_data_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RUN    = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state_q, state_d;
  logic [4:0] step_q,  step_d;
  logic [2:0] req_q;

  // Composite entries, the elementary matrix of the current request and the new entries.
  a2dct_pkg::q_t e_q  [6];
  a2dct_pkg::q_t m_q  [6];
  a2dct_pkg::q_t nw_q [6];
  a2dct_pkg::q_t xa_q, ya_q, px_q, py_q;
  a2dct_pkg::q_t rx_q, ry_q;
  a2dct_pkg::out_word_t out_q;
  logic          out_valid_q;

  a2dct_pkg::q_t    sin_v, cos_v;
  a2dct_pkg::q_t    op_a, op_b;
  a2dct_pkg::step_t step_c, step_m;
  logic signed [63:0] prod;
  a2dct_pkg::wr_t   wr;

  logic       accept;
  logic [4:0] prefix;
  logic [4:0] last_step;
  logic [4:0] p;
  logic [3:0] o;
  logic       t;
  logic       out_free;

  assign accept   = in_valid_i & in_ready_o;
  assign out_free = ~out_valid_q | out_ready_i;

  a2dct_sine u_sine (
    .angle_i (in_data_i.angle[a2dct_pkg::ANGLE_BITS-1:0]),
    .sin_o   (sin_v),
    .cos_o   (cos_v)
  );

  // Steps that build the elementary matrix come first; the twelve product steps of the
  // premultiply follow them.
  always_comb begin
    case (req_q)
      a2dct_pkg::REQ_SCALE: prefix = 5'd2;
      a2dct_pkg::REQ_ROT:   prefix = 5'd4;
      default:              prefix = 5'd0;
    endcase
    last_step = (req_q == a2dct_pkg::REQ_VERT) ? 5'd3 : prefix + 5'd11;
  end

  assign p = step_q - prefix;
  assign o = p[4:1];
  assign t = p[0];

  // Operand selection for the step issued this cycle.
  always_comb begin
    op_a        = '0;
    op_b        = '0;
    step_c      = '0;
    step_c.valid = (state_q == S_RUN);
    step_c.dst  = a2dct_pkg::DST_NW;
    if (req_q == a2dct_pkg::REQ_VERT) begin
      step_c.first = ~step_q[0];
      step_c.last  = step_q[0];
      case (step_q[1:0])
        2'd0: begin
          op_a = e_q[0]; op_b = xa_q; step_c.base = e_q[2]; step_c.dst = a2dct_pkg::DST_RX;
        end
        2'd1: begin
          op_a = e_q[1]; op_b = ya_q; step_c.dst = a2dct_pkg::DST_RX;
        end
        2'd2: begin
          op_a = e_q[3]; op_b = xa_q; step_c.base = e_q[5]; step_c.dst = a2dct_pkg::DST_RY;
        end
        default: begin
          op_a = e_q[4]; op_b = ya_q; step_c.dst = a2dct_pkg::DST_RY;
        end
      endcase
    end else if (step_q < prefix) begin
      if (req_q == a2dct_pkg::REQ_SCALE) begin
        step_c.first = 1'b1;
        step_c.last  = 1'b1;
        step_c.neg   = 1'b1;
        if (step_q[0]) begin
          op_a = ya_q; op_b = py_q; step_c.base = py_q; step_c.dst = a2dct_pkg::DST_M5;
        end else begin
          op_a = xa_q; op_b = px_q; step_c.base = px_q; step_c.dst = a2dct_pkg::DST_M2;
        end
      end else begin
        // Rotation: m2 = px - px*c + py*s and m5 = py - py*c - px*s.
        step_c.first = ~step_q[0];
        step_c.last  = step_q[0];
        case (step_q[1:0])
          2'd0: begin
            op_a = px_q; op_b = m_q[4]; step_c.neg = 1'b1; step_c.base = px_q;
            step_c.dst = a2dct_pkg::DST_M2;
          end
          2'd1: begin
            op_a = py_q; op_b = m_q[3]; step_c.dst = a2dct_pkg::DST_M2;
          end
          2'd2: begin
            op_a = py_q; op_b = m_q[4]; step_c.neg = 1'b1; step_c.base = py_q;
            step_c.dst = a2dct_pkg::DST_M5;
          end
          default: begin
            op_a = px_q; op_b = m_q[3]; step_c.neg = 1'b1; step_c.dst = a2dct_pkg::DST_M5;
          end
        endcase
      end
    end else begin
      // New entry o: row o/3, column o%3, two products and the offset in column two.
      step_c.first = ~t;
      step_c.last  = t;
      step_c.idx   = o[2:0];
      case (o)
        4'd0: begin op_a = t ? m_q[1] : m_q[0]; op_b = t ? e_q[3] : e_q[0]; end
        4'd1: begin op_a = t ? m_q[1] : m_q[0]; op_b = t ? e_q[4] : e_q[1]; end
        4'd2: begin
          op_a = t ? m_q[1] : m_q[0]; op_b = t ? e_q[5] : e_q[2]; step_c.base = m_q[2];
        end
        4'd3: begin op_a = t ? m_q[4] : m_q[3]; op_b = t ? e_q[3] : e_q[0]; end
        4'd4: begin op_a = t ? m_q[4] : m_q[3]; op_b = t ? e_q[4] : e_q[1]; end
        default: begin
          op_a = t ? m_q[4] : m_q[3]; op_b = t ? e_q[5] : e_q[2]; step_c.base = m_q[5];
        end
      endcase
    end
  end

  a2dct_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (op_a),
    .b_i    (op_b),
    .step_i (step_c),
    .prod_o (prod),
    .step_o (step_m)
  );

  a2dct_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .prod_i (prod),
    .step_i (step_m),
    .wr_o   (wr)
  );

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        step_d = '0;
        if (accept) begin
          case (in_data_i.req_type)
            a2dct_pkg::REQ_TRANS, a2dct_pkg::REQ_SCALE,
            a2dct_pkg::REQ_ROT, a2dct_pkg::REQ_VERT: state_d = S_RUN;
            default:                                 state_d = S_IDLE;
          endcase
        end
      end
      S_RUN: begin
        step_d = step_q + 5'd1;
        if (step_q == last_step) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = (req_q == a2dct_pkg::REQ_VERT) ? S_OUT : S_COMMIT;
      end
      S_COMMIT: begin
        state_d = S_IDLE;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      req_q       <= a2dct_pkg::REQ_IDENT;
      out_valid_q <= 1'b0;
      e_q[0]      <= a2dct_pkg::ONE_Q;
      e_q[1]      <= '0;
      e_q[2]      <= '0;
      e_q[3]      <= '0;
      e_q[4]      <= a2dct_pkg::ONE_Q;
      e_q[5]      <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (accept) begin
        req_q <= in_data_i.req_type;
        if (in_data_i.req_type == a2dct_pkg::REQ_IDENT) begin
          e_q[0] <= a2dct_pkg::ONE_Q;
          e_q[1] <= '0;
          e_q[2] <= '0;
          e_q[3] <= '0;
          e_q[4] <= a2dct_pkg::ONE_Q;
          e_q[5] <= '0;
        end
      end
      if (state_q == S_COMMIT) begin
        for (int i = 0; i < 6; i++) begin
          e_q[i] <= nw_q[i];
        end
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: request operands, elementary matrix, new entries, results.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      xa_q <= in_data_i.x_a;
      ya_q <= in_data_i.y_a;
      px_q <= in_data_i.pivot_x;
      py_q <= in_data_i.pivot_y;
      case (in_data_i.req_type)
        a2dct_pkg::REQ_SCALE: begin
          m_q[0] <= in_data_i.x_a;
          m_q[1] <= '0;
          m_q[3] <= '0;
          m_q[4] <= in_data_i.y_a;
        end
        a2dct_pkg::REQ_ROT: begin
          m_q[0] <= cos_v;
          m_q[1] <= -sin_v;
          m_q[3] <= sin_v;
          m_q[4] <= cos_v;
        end
        default: begin
          m_q[0] <= a2dct_pkg::ONE_Q;
          m_q[1] <= '0;
          m_q[3] <= '0;
          m_q[4] <= a2dct_pkg::ONE_Q;
        end
      endcase
      m_q[2] <= in_data_i.x_a;
      m_q[5] <= in_data_i.y_a;
    end
    if (wr.valid) begin
      case (wr.dst)
        a2dct_pkg::DST_M2: m_q[2] <= wr.data;
        a2dct_pkg::DST_M5: m_q[5] <= wr.data;
        a2dct_pkg::DST_RX: rx_q   <= wr.data;
        a2dct_pkg::DST_RY: ry_q   <= wr.data;
        default: begin
          case (wr.idx)
            3'd0:    nw_q[0] <= wr.data;
            3'd1:    nw_q[1] <= wr.data;
            3'd2:    nw_q[2] <= wr.data;
            3'd3:    nw_q[3] <= wr.data;
            3'd4:    nw_q[4] <= wr.data;
            default: nw_q[5] <= wr.data;
          endcase
        end
      endcase
    end
    if (state_q == S_OUT && out_free) begin
      out_q.out_x <= rx_q;
      out_q.out_y <= ry_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> bench/a2dct_checker.sv
// Checker for the 2-D composite transform: watches both channels, predicts vertex words.
// Depends on a2dct_pkg for the word types, request codes and fixed-point widths.
module a2dct_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  a2dct_pkg::in_word_t  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  a2dct_pkg::out_word_t out_data_i,
  output int                   errors_o,
  output int                   pending_o
);
  import a2dct_pkg::*;

  q_t             matrix [6] = '{ONE_Q, 0, 0, 0, ONE_Q, 0};
  out_word_t      vertex_q [$];
  longint         sine_tab [QN+1];
  int             err_cnt = 0;
  int             pend_q  = 0;

  assign errors_o  = err_cnt;
  assign pending_o = pend_q;

  function automatic longint unsigned q62_mul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Taylor series in unsigned Q2.62 with truncating steps, then rounded half up.
  function automatic longint quarter_wave(int i);
    longint unsigned x, x2, term, sum, ii;
    ii   = longint'(i);
    x    = (PI_HALF_Q62 >> QS) * ii + (((PI_HALF_Q62 & ((64'd1 << QS) - 1)) * ii) >> QS);
    x2   = q62_mul(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n <= 15; n++) begin
      term = q62_mul(term, x2) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return longint'((sum + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
  endfunction

  function automatic longint angle_sine(int a);
    int q, r, idx;
    q   = (a >> QS) & 3;
    r   = a & (QN - 1);
    idx = (q & 1) ? QN - r : r;
    return (q & 2) ? -sine_tab[idx] : sine_tab[idx];
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic q_t clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return q_t'(v);
  endfunction

  task automatic load_identity();
    matrix = '{ONE_Q, 0, 0, 0, ONE_Q, 0};
  endtask

  // New matrix is the elementary one times the current one.
  task automatic premultiply(longint e [6]);
    q_t nxt [6];
    longint s;
    for (int r = 0; r < 2; r++) begin
      for (int j = 0; j < 3; j++) begin
        s = fx_mul(e[r*3], matrix[j]) + fx_mul(e[r*3+1], matrix[3+j]);
        if (j == 2) s += e[r*3+2];
        nxt[r*3+j] = clamp32(s);
      end
    end
    matrix = nxt;
  endtask

  task automatic apply_request(in_word_t w);
    longint e [6];
    longint xa, ya, px, py, sn, cs;
    int ang;
    out_word_t o;
    xa  = w.x_a;
    ya  = w.y_a;
    px  = w.pivot_x;
    py  = w.pivot_y;
    ang = int'(w.angle) & ((1 << ANGLE_BITS) - 1);
    case (w.req_type)
      REQ_IDENT: load_identity();
      REQ_TRANS: begin
        e = '{ONE_Q, 0, xa, 0, ONE_Q, ya};
        premultiply(e);
      end
      REQ_SCALE: begin
        e = '{xa, 0, clamp32(px - fx_mul(xa, px)), 0, ya, clamp32(py - fx_mul(ya, py))};
        premultiply(e);
      end
      REQ_ROT: begin
        sn = angle_sine(ang);
        cs = angle_sine((ang + QN) & ((1 << ANGLE_BITS) - 1));
        e = '{cs, -sn, clamp32(px - fx_mul(px, cs) + fx_mul(py, sn)),
              sn, cs, clamp32(py - fx_mul(py, cs) - fx_mul(px, sn))};
        premultiply(e);
      end
      REQ_VERT: begin
        o.out_x = clamp32(fx_mul(matrix[0], xa) + fx_mul(matrix[1], ya) + matrix[2]);
        o.out_y = clamp32(fx_mul(matrix[3], xa) + fx_mul(matrix[4], ya) + matrix[5]);
        vertex_q.push_back(o);
      end
      default: ;
    endcase
  endtask

  initial begin
    for (int i = 0; i <= QN; i++) sine_tab[i] = quarter_wave(i);
  end

  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (vertex_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("ERROR: unexpected vertex word x=%h y=%h",
                                      out_data_i.out_x, out_data_i.out_y);
        end else begin
          exp_w = vertex_q.pop_front();
          if (exp_w.out_x !== out_data_i.out_x || exp_w.out_y !== out_data_i.out_y) begin
            err_cnt++;
            if (err_cnt <= 10) $display("ERROR: vertex mismatch exp x=%h y=%h got x=%h y=%h",
                                        exp_w.out_x, exp_w.out_y,
                                        out_data_i.out_x, out_data_i.out_y);
          end
        end
      end
      if (in_valid_i && in_ready_i) apply_request(in_data_i);
      pend_q <= vertex_q.size();
    end
  end
endmodule

>>> bench/tb_affine_2d_composite_transform.sv
// Testbench top for the 2-D composite transform: clock, reset, request words and verdict.
// Depends on a2dct_pkg, the block and the a2dct_checker module that does the prediction.
module tb_affine_2d_composite_transform;
  import a2dct_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  int        errors;
  int        pending;
  int        quiet_cycles = 0;
  logic      calm;

  affine_2d_composite_transform u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // The checker sees exactly what the block sees and keeps its own matrix copy.
  a2dct_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The receiver stalls about a fifth of the time, except during the calm stretch.
  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= 21);
  end

  // Watchdog: the run is declared hung when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Presents one request word and holds it until the block takes it. A gap, if any,
  // follows the accept so valid never drops and rises again in the same step.
  task automatic send_word(logic [2:0] req, q_t xa, q_t ya, q_t px, q_t py,
                           logic [9:0] ang);
    in_data  <= '{req_type: req, x_a: xa, y_a: ya, pivot_x: px, pivot_y: py, angle: ang};
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    if (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
  endtask

  // Mostly small Q16.16 magnitudes so the matrix stays meaningful, with some full range.
  function automatic q_t pick_value(int span);
    if ($urandom_range(99) < 25) return q_t'($urandom);
    return q_t'($signed($urandom_range(2 * span)) - span);
  endfunction

  task automatic send_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      send_word(REQ_IDENT, q_t'($urandom), q_t'($urandom), q_t'($urandom), q_t'($urandom),
                10'($urandom));
    end else if (pick < 24) begin
      send_word(REQ_TRANS, pick_value(32'h40000), pick_value(32'h40000),
                q_t'($urandom), q_t'($urandom), 10'($urandom));
    end else if (pick < 38) begin
      send_word(REQ_SCALE, pick_value(32'h20000), pick_value(32'h20000),
                pick_value(32'h40000), pick_value(32'h40000), 10'($urandom));
    end else if (pick < 56) begin
      send_word(REQ_ROT, q_t'($urandom), q_t'($urandom),
                pick_value(32'h40000), pick_value(32'h40000), 10'($urandom));
    end else if (pick < 94) begin
      send_word(REQ_VERT, pick_value(32'h80000), pick_value(32'h80000),
                q_t'($urandom), q_t'($urandom), 10'($urandom));
    end else begin
      // Unused request codes must be swallowed without a result.
      send_word(3'($urandom_range(7, 5)), q_t'($urandom), q_t'($urandom),
                q_t'($urandom), q_t'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    q_t qmax, qmin;
    qmax         = 32'sh7fffffff;
    qmin         = 32'sh80000000;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    calm         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset matrix, field extremes, every request and the odd codes.
    send_word(REQ_VERT, qmax, qmin, 0, 0, 0);
    send_word(REQ_VERT, 32'sh00018000, -32'sh00024000, qmax, qmin, 10'h3ff);
    send_word(REQ_TRANS, qmax, qmin, 0, 0, 0);
    send_word(REQ_VERT, qmax, qmax, 0, 0, 0);
    send_word(REQ_IDENT, qmax, qmin, qmax, qmin, 10'h3ff);
    send_word(REQ_SCALE, 32'sh00020000, 32'sh00008000, 32'sh00010000, -32'sh00030000, 0);
    send_word(REQ_VERT, 32'sh00050000, 32'sh00070000, 0, 0, 0);
    send_word(REQ_SCALE, qmax, qmin, qmin, qmax, 0);
    send_word(REQ_VERT, 32'sh00010000, -32'sh00010000, 0, 0, 0);
    send_word(REQ_IDENT, 0, 0, 0, 0, 0);
    for (int a = 0; a < 5; a++) begin
      send_word(REQ_ROT, 0, 0, 32'sh00020000, -32'sh00010000,
                (a == 4) ? 10'h3ff : 10'(a * 256 + 1));
      send_word(REQ_VERT, 32'sh00030000, 32'sh00010000, 0, 0, 0);
    end
    send_word(REQ_ROT, 0, 0, qmax, qmin, 10'd256);
    send_word(3'd5, qmax, qmax, qmax, qmax, 10'h3ff);
    send_word(3'd6, 0, 0, 0, 0, 0);
    send_word(3'd7, qmin, qmin, qmin, qmin, 10'h155);
    send_word(REQ_VERT, qmin, qmax, 0, 0, 0);
    send_word(REQ_IDENT, 0, 0, 0, 0, 0);

    // Random part, with a calm stretch and one full drain partway through.
    for (int n = 0; n < 750; n++) begin
      calm = (n >= 300 && n < 400);
      if (n == 450) begin
        in_valid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      send_random();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/a2dct_pkg.sv
rtl/a2dct_sine.sv
rtl/a2dct_mul.sv
rtl/a2dct_acc.sv
rtl/affine_2d_composite_transform.sv
bench/a2dct_checker.sv
bench/tb_affine_2d_composite_transform.sv
